[sv/stuffed_frame_receiver_crc8_assert.svh]
// Assertion macros for the stuffed frame receiver.
// Included by stuffed_frame_receiver_crc8, which checks its own logic; no other dependencies.
`ifndef STUFFED_FRAME_RECEIVER_CRC8_ASSERT_SVH
`define STUFFED_FRAME_RECEIVER_CRC8_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked on every clock edge outside reset.
`define SFRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define SFRC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`else

`define SFRC_ASSERT_IMPL(label, ante, cons, msg)
`define SFRC_ASSERT_ALWAYS(label, cond, msg)

`endif

`endif

[sv/sfrc_pkg.sv]
// Package for the stuffed frame receiver: protocol byte codes and the check step.
// No dependencies; imported by stuffed_frame_receiver_crc8.
`default_nettype none

package sfrc_pkg;

  localparam logic [7:0] SYNC_ESC   = 8'hD7;  // first byte of the start pair
  localparam logic [7:0] SYNC_START = 8'h29;  // second byte of the start pair
  localparam logic [7:0] STUFF_BYTE = 8'h00;  // stuffing byte after an escape
  localparam logic [7:0] CHK_POLY   = 8'h3C;

  localparam logic [7:0] POS_ADDR  = 8'd3;
  localparam logic [7:0] POS_CMD   = 8'd4;
  localparam logic [7:0] POS_LEN   = 8'd5;
  localparam logic [7:0] POS_START = 8'd2;    // index reported for a start pair
  localparam logic [7:0] HDR_LEN   = 8'd6;

  // One step of the check: xor in the byte, rotate right, fold in the
  // polynomial when the new top bit is set.
  function automatic logic [7:0] chk_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] x;
    x = c ^ b;
    x = {x[0], x[7:1]};
    if (x[7]) begin
      x = x ^ CHK_POLY;
    end
    return x;
  endfunction

endpackage

`default_nettype wire

[sv/stuffed_frame_receiver_crc8.sv]
// Stuffed frame receiver with an 8-bit rotate-and-xor check.
// Depends on sfrc_pkg and the assertion macros in stuffed_frame_receiver_crc8_assert.svh.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ---------------------------------------------
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  byte_kept, kept_value, kept_position,
//                                    frame_end, check_match, address_match,
//                                    frame_command, payload_length, overflow_drop
//   config    cfg_write_en           cfg_write_data (device_address)
//
// Each item passes through two registers: the input register holds the received
// byte, and the frame state plus the result register update together when it
// moves on. out_valid rises when the item moves from the input register into the
// result register, which an output stall can delay. One item is taken per cycle
// as long as out_ready is high, because the whole decode, with its single check
// step on the frame state loop, fits between the two registers. A stall on the
// output holds both registers, and the input still takes an item while its
// register is empty.
// Synchronous active-high reset clears the frame state and both valid flags
// and loads device_address with 5.
`default_nettype none
`include "stuffed_frame_receiver_crc8_assert.svh"

module stuffed_frame_receiver_crc8
  import sfrc_pkg::*;
#(
  parameter int unsigned COUNT_LIMIT = 250
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_write_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            byte_kept,
  output logic [7:0]      kept_value,
  output logic [7:0]      kept_position,
  output logic            frame_end,
  output logic            check_match,
  output logic            address_match,
  output logic [7:0]      frame_command,
  output logic [7:0]      payload_length,
  output logic            overflow_drop
);

  localparam logic [7:0] LIMIT = 8'(COUNT_LIMIT);

  // Configuration register.
  logic [7:0] device_address;

  // Input register.
  logic       in_full;
  logic [7:0] in_byte;

  // Frame state.
  logic [7:0] byte_count,        byte_count_next;
  logic       escape_pending,    escape_pending_next;
  logic       start_seen,        start_seen_next;
  logic [7:0] length_field,      length_field_next;
  logic [7:0] check_running,     check_running_next;
  logic [7:0] check_before_last, check_before_last_next;
  logic [7:0] header_address,    header_address_next;
  logic [7:0] header_command,    header_command_next;

  // Decode results for the byte in the input register.
  logic       kept, do_store, fend, cm, am, ovf;
  logic [7:0] kpos;
  logic       advance;

  // The input register moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd5;
    end else if (cfg_write_en) begin
      device_address <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // Frame decode for one byte. The overrun test comes first; otherwise the
  // byte is classified as escape, start, stuffing or ordinary data, stored
  // where the protocol keeps it, and the end of frame is judged on the
  // updated count and length.
  always_comb begin
    byte_count_next        = byte_count;
    escape_pending_next    = escape_pending;
    start_seen_next        = start_seen;
    length_field_next      = length_field;
    check_running_next     = check_running;
    check_before_last_next = check_before_last;
    header_address_next    = header_address;
    header_command_next    = header_command;
    kept     = 1'b0;
    do_store = 1'b0;
    kpos     = 8'd0;
    fend     = 1'b0;
    cm       = 1'b0;
    am       = 1'b0;
    ovf      = 1'b0;

    if (byte_count > LIMIT) begin
      // The count ran past the limit: drop the byte and start over.
      byte_count_next        = 8'd0;
      check_running_next     = 8'd0;
      check_before_last_next = 8'd0;
      ovf                    = 1'b1;
    end else begin
      if (in_byte == SYNC_ESC) begin
        do_store            = 1'b1;
        escape_pending_next = 1'b1;
      end else if (in_byte == SYNC_START) begin
        if (escape_pending) begin
          // A start pair reloads the frame as 00 D7 29.
          check_before_last_next = chk_step(chk_step(8'd0, STUFF_BYTE), SYNC_ESC);
          check_running_next     = chk_step(check_before_last_next, SYNC_START);
          byte_count_next        = POS_ADDR;
          start_seen_next        = 1'b1;
          kept                   = 1'b1;
          kpos                   = POS_START;
        end else begin
          do_store = 1'b1;
        end
        escape_pending_next = 1'b0;
      end else if (in_byte == STUFF_BYTE) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else begin
          do_store = 1'b1;
        end
      end else if (start_seen) begin
        do_store            = 1'b1;
        escape_pending_next = 1'b0;
      end

      if (do_store) begin
        kept = 1'b1;
        kpos = byte_count;
        if (byte_count == POS_ADDR) begin
          header_address_next = in_byte;
        end
        if (byte_count == POS_CMD) begin
          header_command_next = in_byte;
        end
        if (byte_count == POS_LEN) begin
          length_field_next = in_byte;
        end
        check_before_last_next = check_running;
        check_running_next     = chk_step(check_running, in_byte);
        byte_count_next        = byte_count + 8'd1;
      end

      // The sum is taken at nine bits so that a long length never wraps.
      if (byte_count_next > HDR_LEN &&
          {1'b0, byte_count_next} == {1'b0, HDR_LEN} + {1'b0, length_field_next}) begin
        fend = 1'b1;
        cm   = kept && (check_before_last_next == in_byte);
        am   = (header_address_next == device_address);
        escape_pending_next    = 1'b0;
        start_seen_next        = 1'b0;
        byte_count_next        = 8'd0;
        check_running_next     = 8'd0;
        check_before_last_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= 8'd0;
      escape_pending    <= 1'b0;
      start_seen        <= 1'b0;
      length_field      <= 8'd0;
      check_running     <= 8'd0;
      check_before_last <= 8'd0;
      header_address    <= 8'd0;
      header_command    <= 8'd0;
    end else if (in_full && advance) begin
      byte_count        <= byte_count_next;
      escape_pending    <= escape_pending_next;
      start_seen        <= start_seen_next;
      length_field      <= length_field_next;
      check_running     <= check_running_next;
      check_before_last <= check_before_last_next;
      header_address    <= header_address_next;
      header_command    <= header_command_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (in_full && advance) begin
      byte_kept      <= kept;
      kept_value     <= kept ? in_byte : 8'd0;
      kept_position  <= kpos;
      frame_end      <= fend;
      check_match    <= cm;
      address_match  <= fend && am;
      frame_command  <= header_command_next;
      payload_length <= length_field_next;
      overflow_drop  <= ovf;
    end
  end

  // A frame can only end on a byte that was stored.
  `SFRC_ASSERT_IMPL(a_end_needs_kept, out_valid && frame_end, byte_kept,
                    "frame end reported on a byte that was not stored")
  // An overrun drops the byte and never closes a frame.
  `SFRC_ASSERT_IMPL(a_ovf_drops, out_valid && overflow_drop, !byte_kept && !frame_end,
                    "overrun item stored a byte or ended a frame")
  // Comparison flags are only meaningful at a frame end.
  `SFRC_ASSERT_IMPL(a_match_at_end, out_valid && (check_match || address_match), frame_end,
                    "match flag raised outside a frame end")
  // The count never climbs more than one past the limit.
  `SFRC_ASSERT_ALWAYS(a_count_bound, {1'b0, byte_count} <= {1'b0, LIMIT} + 9'd1,
                      "byte count ran beyond the overrun limit")
  // The frame state only changes when an item leaves the input register.
  `SFRC_ASSERT_IMPL(a_state_hold, !(in_full && advance),
                    ##1 ($stable(byte_count) && $stable(check_running)),
                    "frame state changed without an item moving on")

endmodule

`default_nettype wire
